// ===== hdl/ait_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ait_pkg: shared types and codes for the aging instance table
// Holds the action and status codes, the sequencer states and the entry record.
// ----------------------------------------------------------------------------
package ait_pkg;

   localparam logic [2:0] ACT_OBSERVE    = 3'd0;
   localparam logic [2:0] ACT_INVALIDATE = 3'd1;
   localparam logic [2:0] ACT_PRUNE      = 3'd2;
   localparam logic [2:0] ACT_FIND_ADDR  = 3'd3;
   localparam logic [2:0] ACT_FIND_ID    = 3'd4;
   // unassigned action codes span this range
   localparam logic [2:0] ACT_RSVD_LO    = 3'd5;
   localparam logic [2:0] ACT_RSVD_HI    = 3'd7;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [15:0] type_tag;
      logic [63:0] addr;
      logic [31:0] ident;
      logic [15:0] db;
      logic [15:0] label;
      logic        root;
      logic        old;
      logic [31:0] born;
      logic [31:0] seen;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage : ait_pkg
`default_nettype wire

// ===== hdl/aging_instance_table_unit.sv =====
`default_nettype none
// Operation: an action scans the live entries one per cycle through the entry RAM
// and stops early on a hit; unused action codes skip the scan and go straight to
// the result. One item at a time: busy stays high until the result strobe. The
// result is shown for one cycle on rsp_valid; the receiver cannot stall. Reset
// empties the table (fill count to zero) and sets the next id to one.
// ----------------------------------------------------------------------------
// aging_instance_table_unit: aging associative table of tracked objects
// Entries live in one RAM as a prefix in insertion order; a sequencer walks
// them through a single compare and update path for every action.
// ----------------------------------------------------------------------------
module aging_instance_table_unit #(
   parameter int ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_action,
   input  wire logic [15:0] req_type_tag,
   input  wire logic [15:0] req_type_db_id,
   input  wire logic [63:0] req_address,
   input  wire logic [15:0] req_label_tag,
   input  wire logic        req_pin_root,
   input  wire logic [31:0] req_frame_now,
   input  wire logic [31:0] req_age_limit,
   input  wire logic [31:0] req_lookup_id,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_rec_id,
   output logic [15:0]      rsp_rec_type_tag,
   output logic [15:0]      rsp_rec_db_id,
   output logic [63:0]      rsp_rec_address,
   output logic [15:0]      rsp_rec_label_tag,
   output logic             rsp_rec_pinned,
   output logic             rsp_rec_stale,
   output logic [31:0]      rsp_rec_first_frame,
   output logic [31:0]      rsp_rec_last_frame,
   output logic [8:0]       rsp_live_count,
   output logic [8:0]       rsp_stale_total
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

   ait_pkg::state_type state_ff, state_in;

   logic [2:0]  act_ff;
   logic [15:0] type_ff, db_ff, label_ff;
   logic [63:0] addr_ff;
   logic        root_ff;
   logic [31:0] frame_ff, limit_ff, want_ff;

   logic [CNT_W-1:0] live_ff, live_in;
   logic [CNT_W-1:0] stale_ff, stale_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic [CNT_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] acc_ff, acc_in;
   logic [31:0]      next_id_ff, next_id_in;
   logic             dvld_ff, dvld_in;
   logic [IDX_W-1:0] didx_ff, didx_in;
   logic [1:0]       status_ff, status_in;
   ait_pkg::entry_type rec_ff, rec_in;

   logic                  accept;
   logic                  rd_en, wr_en;
   logic [IDX_W-1:0]      wr_addr;
   ait_pkg::entry_type    wr_entry, ent, upd;
   logic [ait_pkg::ENTRY_W-1:0] rd_data;
   logic                  hit, scan_end, keep;
   logic [31:0]           age;
   logic [CNT_W+8:0]      live_ext, stale_ext;

   ait_ram #(
      .WIDTH(ait_pkg::ENTRY_W),
      .DEPTH(ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (rd_en),
      .rd_addr(issue_ff[IDX_W-1:0]),
      .rd_data(rd_data)
   );

   assign ent    = ait_pkg::entry_type'(rd_data);
   assign busy   = (state_ff != ait_pkg::S_IDLE);
   assign accept = start && !busy;

   // compare unit shared by the observe and lookup actions, plus scan-end and age checks
   always_comb begin
      hit = 1'b0;
      if (dvld_ff) begin
         case (act_ff)
            ait_pkg::ACT_OBSERVE:   hit = (ent.addr == addr_ff) && (ent.type_tag == type_ff);
            ait_pkg::ACT_FIND_ADDR: hit = (ent.addr == addr_ff);
            ait_pkg::ACT_FIND_ID:   hit = (ent.ident == want_ff);
            default:                hit = 1'b0;
         endcase
      end
      scan_end = !dvld_ff && (issue_ff >= live_ff);
      age      = (frame_ff >= ent.seen) ? (frame_ff - ent.seen) : 32'd0;
      keep     = !(ent.old && !ent.root && (age >= limit_ff));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ait_pkg::S_IDLE: begin
            if (accept) begin
               state_in = (req_action <= ait_pkg::ACT_FIND_ID) ? ait_pkg::S_SCAN
                                                               : ait_pkg::S_RESP;
            end
         end
         ait_pkg::S_SCAN: begin
            if (hit || scan_end) begin
               state_in = ait_pkg::S_RESP;
            end
         end
         ait_pkg::S_RESP: state_in = ait_pkg::S_IDLE;
         default:         state_in = ait_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      live_in    = live_ff;
      stale_in   = stale_ff;
      issue_in   = issue_ff;
      wr_ptr_in  = wr_ptr_ff;
      acc_in     = acc_ff;
      next_id_in = next_id_ff;
      dvld_in    = 1'b0;
      didx_in    = issue_ff[IDX_W-1:0];
      status_in  = status_ff;
      rec_in     = rec_ff;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = didx_ff;
      wr_entry   = ent;
      upd        = ent;

      unique case (state_ff)
         ait_pkg::S_IDLE: begin
            if (accept) begin
               issue_in  = '0;
               wr_ptr_in = '0;
               acc_in    = '0;
               status_in = ait_pkg::ST_OK;
               rec_in    = '0;
            end
         end
         ait_pkg::S_SCAN: begin
            if (issue_ff < live_ff) begin
               rd_en    = 1'b1;
               dvld_in  = 1'b1;
               issue_in = issue_ff + 1'b1;
            end
            case (act_ff)
               ait_pkg::ACT_OBSERVE: begin
                  if (hit) begin
                     upd.seen = frame_ff;
                     upd.old  = 1'b0;
                     if (db_ff != 16'd0) upd.db = db_ff;
                     if (label_ff != 16'd0) upd.label = label_ff;
                     if (root_ff) upd.root = 1'b1;
                     wr_en    = 1'b1;
                     wr_entry = upd;
                     rec_in   = upd;
                     if (ent.old) stale_in = stale_ff - 1'b1;
                  end else if (scan_end) begin
                     if (live_ff == FULL_CNT) begin
                        status_in = ait_pkg::ST_FULL;
                     end else begin
                        upd.type_tag = type_ff;
                        upd.addr     = addr_ff;
                        upd.ident    = next_id_ff;
                        upd.db       = db_ff;
                        upd.label    = label_ff;
                        upd.root     = root_ff;
                        upd.old      = 1'b0;
                        upd.born     = frame_ff;
                        upd.seen     = frame_ff;
                        wr_en        = 1'b1;
                        wr_addr      = live_ff[IDX_W-1:0];
                        wr_entry     = upd;
                        rec_in       = upd;
                        live_in      = live_ff + 1'b1;
                        next_id_in   = next_id_ff + 32'd1;
                     end
                  end
               end
               ait_pkg::ACT_INVALIDATE: begin
                  if (dvld_ff) begin
                     wr_en        = 1'b1;
                     wr_entry.old = 1'b1;
                  end
                  if (scan_end) stale_in = live_ff;
               end
               ait_pkg::ACT_PRUNE: begin
                  // compact survivors toward the head of the table
                  if (dvld_ff && keep) begin
                     wr_en     = 1'b1;
                     wr_addr   = wr_ptr_ff[IDX_W-1:0];
                     wr_ptr_in = wr_ptr_ff + 1'b1;
                     if (ent.old) acc_in = acc_ff + 1'b1;
                  end
                  if (scan_end) begin
                     live_in  = wr_ptr_ff;
                     stale_in = acc_ff;
                  end
               end
               ait_pkg::ACT_FIND_ADDR, ait_pkg::ACT_FIND_ID: begin
                  if (hit) begin
                     rec_in = ent;
                  end else if (scan_end) begin
                     status_in = ait_pkg::ST_NOT_FOUND;
                  end
               end
               default: ;
            endcase
         end
         ait_pkg::S_RESP: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ait_pkg::S_IDLE;
         live_ff    <= '0;
         stale_ff   <= '0;
         next_id_ff <= 32'd1;
         dvld_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         live_ff    <= live_in;
         stale_ff   <= stale_in;
         next_id_ff <= next_id_in;
         dvld_ff    <= dvld_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff  <= issue_in;
      wr_ptr_ff <= wr_ptr_in;
      acc_ff    <= acc_in;
      didx_ff   <= didx_in;
      status_ff <= status_in;
      rec_ff    <= rec_in;
      if (accept) begin
         act_ff   <= req_action;
         type_ff  <= req_type_tag;
         db_ff    <= req_type_db_id;
         addr_ff  <= req_address;
         label_ff <= req_label_tag;
         root_ff  <= req_pin_root;
         frame_ff <= req_frame_now;
         limit_ff <= req_age_limit;
         want_ff  <= req_lookup_id;
      end
   end

   assign live_ext  = {9'd0, live_ff};
   assign stale_ext = {9'd0, stale_ff};

   assign rsp_valid           = (state_ff == ait_pkg::S_RESP);
   assign rsp_status          = status_ff;
   assign rsp_rec_id          = rec_ff.ident;
   assign rsp_rec_type_tag    = rec_ff.type_tag;
   assign rsp_rec_db_id       = rec_ff.db;
   assign rsp_rec_address     = rec_ff.addr;
   assign rsp_rec_label_tag   = rec_ff.label;
   assign rsp_rec_pinned      = rec_ff.root;
   assign rsp_rec_stale       = rec_ff.old;
   assign rsp_rec_first_frame = rec_ff.born;
   assign rsp_rec_last_frame  = rec_ff.seen;
   assign rsp_live_count      = live_ext[8:0];
   assign rsp_stale_total     = stale_ext[8:0];

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= FULL_CNT) else $error("live count beyond table size");

   a_stale_bound: assert property (@(posedge clock) disable iff (reset)
      stale_ff <= live_ff) else $error("stale count above live count");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("transfer accepted but block not busy");

   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy) else $error("result strobe held");

endmodule : aging_instance_table_unit
`default_nettype wire

// ===== hdl/ait_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ait_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ait_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : ait_ram
`default_nettype wire

// ===== tb/sv/aging_instance_table_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aging_instance_table_checker: scoreboard for the aging instance table
// Watches command and result transfers, keeps its own copy of the table,
// predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module aging_instance_table_checker #(
   parameter int ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [2:0]  req_action,
   input  wire logic [15:0] req_type_tag,
   input  wire logic [15:0] req_type_db_id,
   input  wire logic [63:0] req_address,
   input  wire logic [15:0] req_label_tag,
   input  wire logic        req_pin_root,
   input  wire logic [31:0] req_frame_now,
   input  wire logic [31:0] req_age_limit,
   input  wire logic [31:0] req_lookup_id,
   input  wire logic        rsp_valid,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [31:0] rsp_rec_id,
   input  wire logic [15:0] rsp_rec_type_tag,
   input  wire logic [15:0] rsp_rec_db_id,
   input  wire logic [63:0] rsp_rec_address,
   input  wire logic [15:0] rsp_rec_label_tag,
   input  wire logic        rsp_rec_pinned,
   input  wire logic        rsp_rec_stale,
   input  wire logic [31:0] rsp_rec_first_frame,
   input  wire logic [31:0] rsp_rec_last_frame,
   input  wire logic [8:0]  rsp_live_count,
   input  wire logic [8:0]  rsp_stale_total,
   output int               failures,
   output int               pending
);

   typedef struct packed {
      logic [1:0]         status;
      ait_pkg::entry_type rec;
      logic [8:0]         live;
      logic [8:0]         stale;
   } outcome_type;

   ait_pkg::entry_type table_q[$];
   logic [31:0]        next_id;
   outcome_type        outcomes[$];

   function automatic outcome_type apply_command(
      input logic [2:0] act, input logic [15:0] tag, input logic [15:0] db,
      input logic [63:0] addr, input logic [15:0] label, input logic root,
      input logic [31:0] frame, input logic [31:0] limit, input logic [31:0] want);
      outcome_type        o;
      ait_pkg::entry_type e;
      ait_pkg::entry_type kept[$];
      int                 hit;
      logic [31:0]        age;
      o = '0;
      hit = -1;
      case (act)
         ait_pkg::ACT_OBSERVE: begin
            foreach (table_q[i])
               if (hit < 0 && table_q[i].addr == addr && table_q[i].type_tag == tag) hit = i;
            if (hit >= 0) begin
               e = table_q[hit];
               e.seen = frame;
               e.old = 1'b0;
               if (db != 0) e.db = db;
               if (label != 0) e.label = label;
               if (root) e.root = 1'b1;
               table_q[hit] = e;
               o.rec = e;
            end else if (table_q.size() >= ENTRIES) begin
               o.status = ait_pkg::ST_FULL;
            end else begin
               e = '{type_tag: tag, addr: addr, ident: next_id, db: db, label: label,
                     root: root, old: 1'b0, born: frame, seen: frame};
               table_q = {table_q, e};
               next_id = next_id + 32'd1;
               o.rec = e;
            end
         end
         ait_pkg::ACT_INVALIDATE: foreach (table_q[i]) table_q[i].old = 1'b1;
         ait_pkg::ACT_PRUNE: begin
            foreach (table_q[i]) begin
               age = (frame >= table_q[i].seen) ? frame - table_q[i].seen : 32'd0;
               if (!(table_q[i].old && !table_q[i].root && age >= limit))
                  kept = {kept, table_q[i]};
            end
            table_q = kept;
         end
         ait_pkg::ACT_FIND_ADDR, ait_pkg::ACT_FIND_ID: begin
            foreach (table_q[i])
               if (hit < 0 && (act == ait_pkg::ACT_FIND_ADDR ? table_q[i].addr == addr
                                                             : table_q[i].ident == want))
                  hit = i;
            if (hit >= 0) o.rec = table_q[hit];
            else o.status = ait_pkg::ST_NOT_FOUND;
         end
         default: ;
      endcase
      o.live = 9'(table_q.size());
      foreach (table_q[i]) if (table_q[i].old) o.stale = o.stale + 9'd1;
      return o;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type x;
      if (reset) begin
         table_q.delete();
         outcomes.delete();
         next_id = 32'd1;
         failures = 0;
         pending = 0;
      end else begin
         if (rsp_valid) begin
            if (outcomes.size() == 0) begin
               $error("result with no command outstanding");
               failures++;
            end else begin
               x = outcomes.pop_front();
               compare_field("status", 64'(x.status), 64'(rsp_status));
               compare_field("rec_id", 64'(x.rec.ident), 64'(rsp_rec_id));
               compare_field("rec_type_tag", 64'(x.rec.type_tag), 64'(rsp_rec_type_tag));
               compare_field("rec_db_id", 64'(x.rec.db), 64'(rsp_rec_db_id));
               compare_field("rec_address", x.rec.addr, rsp_rec_address);
               compare_field("rec_label_tag", 64'(x.rec.label), 64'(rsp_rec_label_tag));
               compare_field("rec_pinned", 64'(x.rec.root), 64'(rsp_rec_pinned));
               compare_field("rec_stale", 64'(x.rec.old), 64'(rsp_rec_stale));
               compare_field("rec_first_frame", 64'(x.rec.born), 64'(rsp_rec_first_frame));
               compare_field("rec_last_frame", 64'(x.rec.seen), 64'(rsp_rec_last_frame));
               compare_field("live_count", 64'(x.live), 64'(rsp_live_count));
               compare_field("stale_total", 64'(x.stale), 64'(rsp_stale_total));
            end
         end
         if (start && !busy)
            outcomes = {outcomes, apply_command(req_action, req_type_tag, req_type_db_id,
               req_address, req_label_tag, req_pin_root, req_frame_now,
               req_age_limit, req_lookup_id)};
         pending = outcomes.size();
      end
   end

endmodule : aging_instance_table_checker
`default_nettype wire

// ===== tb/sv/tb_aging_instance_table_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_aging_instance_table_unit: regression for the aging instance table
// Directed commands cover the edges and a fill to capacity, then random commands
// run over a small pool of keys so that hits, prunes and id lookups occur.
// ----------------------------------------------------------------------------
module tb_aging_instance_table_unit;

   localparam int ENTRIES   = 256;
   localparam int NUM_RAND  = 770;
   localparam int WATCHDOG  = 5000;

   logic        clock, reset, start, busy;
   logic [2:0]  req_action;
   logic [15:0] req_type_tag, req_type_db_id, req_label_tag;
   logic [63:0] req_address;
   logic        req_pin_root;
   logic [31:0] req_frame_now, req_age_limit, req_lookup_id;
   logic        rsp_valid, rsp_rec_pinned, rsp_rec_stale;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_rec_id, rsp_rec_first_frame, rsp_rec_last_frame;
   logic [15:0] rsp_rec_type_tag, rsp_rec_db_id, rsp_rec_label_tag;
   logic [63:0] rsp_rec_address;
   logic [8:0]  rsp_live_count, rsp_stale_total;
   int          failures, pending, quiet_cycles;
   logic [63:0] addr_pool[8];
   logic [31:0] frame_clock;
   bit          idle_enable;

   aging_instance_table_unit #(.ENTRIES(ENTRIES)) dut (.*);
   aging_instance_table_checker #(.ENTRIES(ENTRIES)) checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("aging_instance_table_unit regression: fail");
         $finish;
      end
   end

   // Hold the command until the transfer; start stays high into the next
   // command unless an idle burst drops it.
   task automatic issue(input logic [2:0] act, input logic [15:0] tag, input logic [15:0] db,
                        input logic [63:0] addr, input logic [15:0] label, input logic root,
                        input logic [31:0] frame, input logic [31:0] limit,
                        input logic [31:0] want);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_action <= act; req_type_tag <= tag; req_type_db_id <= db;
      req_address <= addr; req_label_tag <= label; req_pin_root <= root;
      req_frame_now <= frame; req_age_limit <= limit; req_lookup_id <= want;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_command();
      logic [2:0]  act;
      logic [63:0] addr;
      logic [15:0] tag;
      int          pick;
      pick = $urandom_range(0, 99);
      act = (pick < 55) ? ait_pkg::ACT_OBSERVE : (pick < 62) ? ait_pkg::ACT_INVALIDATE :
            (pick < 70) ? ait_pkg::ACT_PRUNE : (pick < 83) ? ait_pkg::ACT_FIND_ADDR :
            (pick < 97) ? ait_pkg::ACT_FIND_ID :
            3'($urandom_range(ait_pkg::ACT_RSVD_LO, ait_pkg::ACT_RSVD_HI));
      if ($urandom_range(0, 4) == 0) addr = {$urandom, $urandom};
      else addr = addr_pool[$urandom_range(0, 7)] + 64'($urandom_range(0, 40));
      tag = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      frame_clock = frame_clock + $urandom_range(0, 3);
      issue(act, tag, ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom),
            addr, ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom),
            $urandom_range(0, 7) == 0,
            ($urandom_range(0, 9) == 0) ? $urandom : frame_clock,
            ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 8)),
            ($urandom_range(0, 5) == 0) ? $urandom : 32'($urandom_range(0, 300)));
   endtask

   initial begin
      int wait_cycles;
      start = 1'b0; reset = 1'b1; idle_enable = 1'b1;
      req_action = ait_pkg::ACT_OBSERVE; req_type_tag = '0; req_type_db_id = '0;
      req_address = '0; req_label_tag = '0; req_pin_root = 1'b0;
      req_frame_now = '0; req_age_limit = '0; req_lookup_id = '0;
      frame_clock = 32'd100;
      foreach (addr_pool[i]) addr_pool[i] = {$urandom, $urandom} & ~64'hff;
      addr_pool[0] = 64'd0;
      addr_pool[1] = 64'hffff_ffff_ffff_ff00;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Lookups on an empty table, then edge values.
      issue(ait_pkg::ACT_FIND_ADDR, 0, 0, 64'd0, 0, 0, 0, 0, 0);
      issue(ait_pkg::ACT_FIND_ID, 0, 0, 0, 0, 0, 0, 0, 32'd1);
      issue(ait_pkg::ACT_OBSERVE, 16'hffff, 16'hffff, '1, 16'hffff, 1, '1, 0, 0);
      issue(ait_pkg::ACT_OBSERVE, 16'h0, 16'h0, 64'd0, 16'h0, 0, 32'd0, 0, 0);
      issue(ait_pkg::ACT_OBSERVE, 16'h0, 16'h1234, 64'd0, 16'h0, 0, 32'd50, 0, 0);
      issue(ait_pkg::ACT_OBSERVE, 16'h0, 16'h0, 64'd0, 16'h55aa, 1, 32'd60, 0, 0);
      issue(ait_pkg::ACT_OBSERVE, 16'h0, 16'h0, 64'd0, 16'h0, 0, 32'd70, 0, 0);
      issue(ait_pkg::ACT_OBSERVE, 16'h7, 16'h0, 64'd0, 16'h0, 0, 32'd80, 0, 0);
      issue(ait_pkg::ACT_FIND_ADDR, 0, 0, 64'd0, 0, 0, 0, 0, 0);
      issue(ait_pkg::ACT_FIND_ID, 0, 0, 0, 0, 0, 0, 0, 32'd3);
      issue(ait_pkg::ACT_FIND_ID, 0, 0, 0, 0, 0, 0, 0, '1);
      issue(ait_pkg::ACT_INVALIDATE, '1, '1, '1, '1, 1, '1, '1, '1);
      issue(ait_pkg::ACT_RSVD_LO, 0, 0, 0, 0, 0, 0, 0, 0);
      issue(ait_pkg::ACT_RSVD_HI, '1, '1, '1, '1, 1, '1, '1, '1);
      // Frame behind last seen: age clamps to zero, so limit zero still drops.
      issue(ait_pkg::ACT_PRUNE, 0, 0, 0, 0, 0, 32'd10, 32'd1, 0);
      issue(ait_pkg::ACT_PRUNE, 0, 0, 0, 0, 0, 32'd10, 32'd0, 0);
      issue(ait_pkg::ACT_PRUNE, 0, 0, 0, 0, 0, '1, '1, 0);
      issue(ait_pkg::ACT_FIND_ADDR, 0, 0, '1, 0, 0, 0, 0, 0);

      // Fill to capacity, overflow, then drop all unpinned entries.
      for (int i = 0; i < ENTRIES + 3; i++)
         issue(ait_pkg::ACT_OBSERVE, 16'($urandom), 16'($urandom), {$urandom, $urandom},
               16'($urandom), 0, 32'(i), 0, 0);
      issue(ait_pkg::ACT_INVALIDATE, 0, 0, 0, 0, 0, 0, 0, 0);
      issue(ait_pkg::ACT_PRUNE, 0, 0, 0, 0, 0, 32'd1000, 32'd0, 0);

      for (int n = 0; n < NUM_RAND; n++) begin
         if (n == NUM_RAND - 150) idle_enable = 1'b0;
         random_command();
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (pending != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (ENTRIES + 10) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("aging_instance_table_unit regression: pass");
      else
         $display("aging_instance_table_unit regression: fail");
      $finish;
   end

endmodule : tb_aging_instance_table_unit
`default_nettype wire

// ===== sim.f =====
hdl/ait_pkg.sv
hdl/ait_ram.sv
hdl/aging_instance_table_unit.sv
tb/sv/aging_instance_table_checker.sv
tb/sv/tb_aging_instance_table_unit.sv
